FILE: rtl/stereo_pan_from_positions_top_macros.svh
// Assertion macros for the stereo pan block checkers
`ifndef STEREO_PAN_FROM_POSITIONS_TOP_MACROS_SVH
`define STEREO_PAN_FROM_POSITIONS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SPFP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spfp assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SPFP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spfp assertion failed");

`endif

FILE: rtl/spfp_pkg.sv
// Types, widths and constants shared by the stereo pan block
`timescale 1ns / 1ps
`default_nettype none

package spfp_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;

  // wide coordinates are scaled back to 16-bit product size
  localparam int SHIFT  = (COORD_WIDTH > 16) ? (COORD_WIDTH - 16) : 0;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CW     = SUM_W + 2;
  localparam int ZW     = 33;
  localparam int ACC_W  = 40;

  localparam int ST_CORDIC0 = 3;
  localparam int ST_CLAMP   = ST_CORDIC0 + CORDIC_STEPS;
  localparam int ST_OUT     = ST_CLAMP + 1;
  localparam int NSTAGE     = ST_OUT + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [CW-1:0]          xy_t;
  typedef logic signed [ZW-1:0]          ang_t;
  typedef logic [7:0]                    pan_t;

  typedef struct packed {
    logic degenerate;
    logic det_zero;
    logic dot_zero;
    logic det_neg;
  } flags_t;

  // a quarter turn in binary angle units, full turn = 2^32
  localparam ang_t ANG_QUARTER = 33'sd1073741824;
  localparam ang_t NEG_QUARTER = -33'sd1073741824;
  localparam pan_t PAN_CENTER  = 8'd128;

  // round(atan(2^-i) * 2^32 / (2*pi))
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

`default_nettype wire

FILE: rtl/spfp_if.sv
// Valid/ready channel interfaces for positions in and pan out
`timescale 1ns / 1ps
`default_nettype none

interface spfp_in_if;
  import spfp_pkg::*;

  logic   valid;
  logic   ready;
  coord_t listener_x;
  coord_t listener_z;
  coord_t look_x;
  coord_t look_z;
  coord_t source_x;
  coord_t source_z;

  modport source (
    output valid, listener_x, listener_z, look_x, look_z, source_x, source_z,
    input  ready
  );
  modport sink (
    input  valid, listener_x, listener_z, look_x, look_z, source_x, source_z,
    output ready
  );
endinterface

interface spfp_out_if;
  import spfp_pkg::*;

  logic valid;
  logic ready;
  pan_t pan;
  logic degenerate;

  modport source (
    output valid, pan, degenerate,
    input  ready
  );
  modport sink (
    input  valid, pan, degenerate,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/stereo_pan_from_positions_top.sv
// Stereo pan from listener, look-at and source positions: top level
//
// in_i carries one beat per query: listener, look-at and source x/z
// coordinates, signed 16-bit. out_o returns one beat per query, in order:
// pan (0 full left, 128 center, 255 full right) and degenerate, set when
// the view or source direction has zero length (pan is then 128).
// From the accepting edge to out_o.valid a beat passes three front
// stages (differences, products, dot/cross sums), one stage per CORDIC
// step (16), one clamp stage and the output register. Throughput is one
// beat per cycle while out_o takes results; every stage holds a valid
// bit and the CORDIC is fully unrolled, so nothing is shared between beats.
// A stage advances whenever it is empty or the stage after it moves, so
// in_i.ready stays high while any stage downstream has a bubble, even with
// a result waiting on out_o. When out_o is stalled and all stages are
// full, in_i.ready drops and every beat holds in place.
// Reset (rst_ni low) empties the pipeline; out_o.valid is low after it.
`timescale 1ns / 1ps
`default_nettype none

module stereo_pan_from_positions_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  spfp_in_if.sink     in_i,
  spfp_out_if.source  out_o
);
  import spfp_pkg::*;

  logic [NSTAGE-1:0] vld_d, vld_q;
  logic [NSTAGE-1:0] rdy;

  xy_t    front_x, front_y;
  flags_t front_fl, cordic_fl;
  ang_t   cordic_z;

  ang_t   ang_sel;
  logic [31:0] off_d, off_q;
  logic   deg_c_q;

  logic [ACC_W-1:0] acc;
  pan_t   pan_d, pan_q;
  logic   deg_o_q;

  // a stage moves if it or any stage after it has room
  for (genvar k = 0; k < NSTAGE; k++) begin : g_rdy
    assign rdy[k] = out_o.ready | ~(&vld_q[NSTAGE-1:k]);
  end

  always_comb begin
    vld_d[0] = rdy[0] ? in_i.valid : vld_q[0];
    for (int k = 1; k < NSTAGE; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  spfp_front u_front (
    .clk_i        (clk_i),
    .en_i         (rdy[ST_CORDIC0-1:0]),
    .listener_x_i (in_i.listener_x),
    .listener_z_i (in_i.listener_z),
    .look_x_i     (in_i.look_x),
    .look_z_i     (in_i.look_z),
    .source_x_i   (in_i.source_x),
    .source_z_i   (in_i.source_z),
    .x_o          (front_x),
    .y_o          (front_y),
    .flags_o      (front_fl)
  );

  spfp_cordic u_cordic (
    .clk_i   (clk_i),
    .en_i    (rdy[ST_CLAMP-1:ST_CORDIC0]),
    .x_i     (front_x),
    .y_i     (front_y),
    .flags_i (front_fl),
    .z_o     (cordic_z),
    .flags_o (cordic_fl)
  );

  // pick the angle: straight ahead/behind, exactly sideways, or clamped CORDIC
  always_comb begin
    if (cordic_fl.det_zero) begin
      ang_sel = '0;
    end else if (cordic_fl.dot_zero) begin
      ang_sel = cordic_fl.det_neg ? NEG_QUARTER : ANG_QUARTER;
    end else if (cordic_z > ANG_QUARTER) begin
      ang_sel = ANG_QUARTER;
    end else if (cordic_z < NEG_QUARTER) begin
      ang_sel = NEG_QUARTER;
    end else begin
      ang_sel = cordic_z;
    end
    off_d = 32'(ang_sel + ANG_QUARTER);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_CLAMP]) begin
      off_q   <= off_d;
      deg_c_q <= cordic_fl.degenerate;
    end
  end

  // pan = round(off * 255 / 2^31)
  always_comb begin
    acc   = {off_q, 8'd0} - {8'd0, off_q} + ACC_W'(ANG_QUARTER);
    pan_d = deg_c_q ? PAN_CENTER : acc[38:31];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      pan_q   <= pan_d;
      deg_o_q <= deg_c_q;
    end
  end

  assign in_i.ready       = rdy[0];
  assign out_o.valid      = vld_q[NSTAGE-1];
  assign out_o.pan        = pan_q;
  assign out_o.degenerate = deg_o_q;

endmodule

`default_nettype wire

FILE: rtl/spfp_front.sv
// Front stages: direction vectors, products, dot and cross terms
`timescale 1ns / 1ps
`default_nettype none

module spfp_front (
  input  logic              clk_i,
  input  logic [2:0]        en_i,
  input  spfp_pkg::coord_t  listener_x_i,
  input  spfp_pkg::coord_t  listener_z_i,
  input  spfp_pkg::coord_t  look_x_i,
  input  spfp_pkg::coord_t  look_z_i,
  input  spfp_pkg::coord_t  source_x_i,
  input  spfp_pkg::coord_t  source_z_i,
  output spfp_pkg::xy_t     x_o,
  output spfp_pkg::xy_t     y_o,
  output spfp_pkg::flags_t  flags_o
);
  import spfp_pkg::*;

  diff_t  dx, dz, vx, vz;
  logic   deg_d;
  diff_t  dx_q, dz_q, vx_q, vz_q;
  logic   deg1_q;
  prod_t  p_xx_d, p_zz_d, p_xz_d, p_zx_d;
  prod_t  p_xx_q, p_zz_q, p_xz_q, p_zx_q;
  logic   deg2_q;
  sum_t   dot, det, dot_abs;
  xy_t    x_d, y_d, x_q, y_q;
  flags_t flags_d, flags_q;

  // stage 1: direction vectors and zero-length test
  always_comb begin
    dx    = diff_t'(listener_x_i) - diff_t'(look_x_i);
    dz    = diff_t'(listener_z_i) - diff_t'(look_z_i);
    vx    = diff_t'(listener_x_i) - diff_t'(source_x_i);
    vz    = diff_t'(listener_z_i) - diff_t'(source_z_i);
    deg_d = ((dx == '0) && (dz == '0)) || ((vx == '0) && (vz == '0));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dx_q   <= dx >>> SHIFT;
      dz_q   <= dz >>> SHIFT;
      vx_q   <= vx >>> SHIFT;
      vz_q   <= vz >>> SHIFT;
      deg1_q <= deg_d;
    end
  end

  // stage 2: four products
  always_comb begin
    p_xx_d = prod_t'(dx_q) * prod_t'(vx_q);
    p_zz_d = prod_t'(dz_q) * prod_t'(vz_q);
    p_xz_d = prod_t'(dx_q) * prod_t'(vz_q);
    p_zx_d = prod_t'(dz_q) * prod_t'(vx_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_xx_q <= p_xx_d;
      p_zz_q <= p_zz_d;
      p_xz_q <= p_xz_d;
      p_zx_q <= p_zx_d;
      deg2_q <= deg1_q;
    end
  end

  // stage 3: dot and determinant, fold angles behind the listener forward
  always_comb begin
    dot     = sum_t'(p_xx_q) + sum_t'(p_zz_q);
    det     = sum_t'(p_xz_q) - sum_t'(p_zx_q);
    dot_abs = dot[SUM_W-1] ? -dot : dot;
    x_d     = xy_t'(dot_abs);
    y_d     = xy_t'(det);
    flags_d.degenerate = deg2_q;
    flags_d.det_zero   = (det == '0);
    flags_d.dot_zero   = (dot == '0);
    flags_d.det_neg    = det[SUM_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      x_q     <= x_d;
      y_q     <= y_d;
      flags_q <= flags_d;
    end
  end

  assign x_o     = x_q;
  assign y_o     = y_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

FILE: rtl/spfp_cordic.sv
// Unrolled vectoring CORDIC, one rotation step per register stage
`timescale 1ns / 1ps
`default_nettype none

module spfp_cordic (
  input  logic                                clk_i,
  input  logic [spfp_pkg::CORDIC_STEPS-1:0]   en_i,
  input  spfp_pkg::xy_t                       x_i,
  input  spfp_pkg::xy_t                       y_i,
  input  spfp_pkg::flags_t                    flags_i,
  output spfp_pkg::ang_t                      z_o,
  output spfp_pkg::flags_t                    flags_o
);
  import spfp_pkg::*;

  xy_t    x_q  [CORDIC_STEPS-1];
  xy_t    y_q  [CORDIC_STEPS-1];
  ang_t   z_q  [CORDIC_STEPS];
  flags_t fl_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam ang_t StepAng = ang_t'({1'b0, ATAN_TAB[i]});

    xy_t    xv, yv;
    ang_t   zv, zn;
    flags_t fv;

    if (i == 0) begin : g_first
      assign xv = x_i;
      assign yv = y_i;
      assign zv = '0;
      assign fv = flags_i;
    end else begin : g_rest
      assign xv = x_q[i-1];
      assign yv = y_q[i-1];
      assign zv = z_q[i-1];
      assign fv = fl_q[i-1];
    end

    // rotate toward the x axis: sign of y picks the direction
    assign zn = yv[CW-1] ? (zv - StepAng) : (zv + StepAng);

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        z_q[i]  <= zn;
        fl_q[i] <= fv;
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_xy
      xy_t xs, ys, xn, yn;

      always_comb begin
        xs = xv >>> i;
        ys = yv >>> i;
        if (yv[CW-1]) begin
          xn = xv - ys;
          yn = yv + xs;
        end else begin
          xn = xv + ys;
          yn = yv - xs;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i[i]) begin
          x_q[i] <= xn;
          y_q[i] <= yn;
        end
      end
    end
  end

  assign z_o     = z_q[CORDIC_STEPS-1];
  assign flags_o = fl_q[CORDIC_STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/spfp_checker.sv
// Port-level checks for the stereo pan block, bound to the top level
`include "stereo_pan_from_positions_top_macros.svh"
`timescale 1ns / 1ps
`default_nettype none

module spfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] pan_i,
  input logic       degenerate_i
);

  logic out_stall;

  assign out_stall = out_valid_i && !out_ready_i;

  // a stalled result beat holds its value
  `SPFP_ASSERT_NXT(a_out_hold, out_stall, out_valid_i && $stable(pan_i) && $stable(degenerate_i))

  // input backpressure only comes from a stalled, full pipeline
  `SPFP_ASSERT_IMP(a_in_stall_cause, !in_ready_i, out_stall)

  // a degenerate query always reports center pan
  `SPFP_ASSERT_IMP(a_degen_center, out_valid_i && degenerate_i, pan_i == 8'd128)

  // a waiting input beat with an empty output side is taken at once
  `SPFP_ASSERT_IMP(a_in_taken, in_valid_i && !out_valid_i, in_ready_i)

endmodule

bind stereo_pan_from_positions_top spfp_checker u_spfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .pan_i        (out_o.pan),
  .degenerate_i (out_o.degenerate)
);

`default_nettype wire
